/* rtl/core/skt_pkg.sv */
// Package for the sorted key table: sizes, field widths, opcodes, status codes
// and the per-cell control word. No dependencies.
package skt_pkg;

  localparam int DEPTH        = 32;
  localparam int KEY_BITS     = 64;
  localparam int PAYLOAD_BITS = 32;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Port field widths
  localparam int OPC_W  = 3;
  localparam int KEY_W  = 64;
  localparam int PAY_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 6;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OPC_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OPC_W-1:0] OP_GET    = 3'd3;
  localparam logic [OPC_W-1:0] OP_UPDATE = 3'd4;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // Cell data source select
  localparam logic [1:0] SEL_HOLD  = 2'd0;
  localparam logic [1:0] SEL_BELOW = 2'd1;
  localparam logic [1:0] SEL_ABOVE = 2'd2;
  localparam logic [1:0] SEL_LOAD  = 2'd3;

  typedef struct packed {
    logic       cmp_en;
    logic [1:0] sel;
  } cell_ctl_t;

endpackage

/* rtl/core/sorted_key_table_top.sv */
// Sorted key table top level: request handshake, operation sequencer and the
// cell row. Depends on skt_pkg and skt_row.
// Path from accept to result: errors, a full table, clear and spare opcodes go
// straight to the done state; get and delete read one entry, update writes one;
// find compares, searches and on a hit reads; insert compares, scans and shifts.
// One request at a time: the next one is taken only after its result loads into
// the output register; an output stall holds both sides.
// Reset clears the entry count, the sequencer and the result valid; entries
// hold whatever they had and are never read above the count.
module sorted_key_table_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [skt_pkg::OPC_W-1:0]   in_opcode,
  input  logic [skt_pkg::KEY_W-1:0]   in_key,
  input  logic [skt_pkg::PAY_W-1:0]   in_payload,
  input  logic [skt_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [skt_pkg::STAT_W-1:0]  out_status,
  output logic [skt_pkg::POS_W-1:0]   out_found_position,
  output logic [skt_pkg::KEY_W-1:0]   out_entry_key,
  output logic [skt_pkg::PAY_W-1:0]   out_entry_payload,
  output logic [skt_pkg::ECNT_W-1:0]  out_entry_count
);
  import skt_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;  // all cells compare against the key
  localparam logic [2:0] S_SCAN   = 3'd2;  // walk down from the top for the slot
  localparam logic [2:0] S_SHIFT  = 3'd3;  // shift up and drop in the new entry
  localparam logic [2:0] S_SEARCH = 3'd4;  // binary search on the compare flags
  localparam logic [2:0] S_READ   = 3'd5;  // read one entry, shift down on delete
  localparam logic [2:0] S_WRITE  = 3'd6;  // overwrite one entry
  localparam logic [2:0] S_DONE   = 3'd7;  // hand the result to the output stage

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;

  // Request holding registers
  logic [OPC_W-1:0]        op_r, op_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  // Staged result
  logic [STAT_W-1:0]       res_stat_r, res_stat_nxt;
  logic [POS_W-1:0]        res_pos_r, res_pos_nxt;
  logic [KEY_BITS-1:0]     res_key_r, res_key_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       o_stat_r, o_stat_nxt;
  logic [POS_W-1:0]        o_pos_r, o_pos_nxt;
  logic [KEY_W-1:0]        o_key_r, o_key_nxt;
  logic [PAY_W-1:0]        o_pay_r, o_pay_nxt;
  logic [ECNT_W-1:0]       o_cnt_r, o_cnt_nxt;

  cell_ctl_t [DEPTH-1:0]   ctl;
  logic [KEY_BITS-1:0]     load_key;
  logic [PAYLOAD_BITS-1:0] load_pay;
  logic [DEPTH-1:0]        lt_vec, eq_vec;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  logic                    in_acc, out_free, pos_bad;
  logic [CNT_W-1:0]        ptr_m1;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pos_bad  = (CMP_W'(in_position) >= CMP_W'(count_r));
  assign ptr_m1   = CNT_W'(ptr_r - CNT_W'(1));
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CNT_W:1];

  // New data goes to the cells straight from the request registers
  assign load_key = key_r;
  assign load_pay = pay_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    rd_idx_nxt   = rd_idx_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    pay_nxt      = pay_r;
    res_stat_nxt = res_stat_r;
    res_pos_nxt  = res_pos_r;
    res_key_nxt  = res_key_r;
    res_pay_nxt  = res_pay_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_opcode;
          key_nxt      = in_key[KEY_BITS-1:0];
          pay_nxt      = PAYLOAD_BITS'(in_payload);
          rd_idx_nxt   = IDX_W'(in_position);
          res_stat_nxt = STAT_OK;
          res_pos_nxt  = '0;
          res_key_nxt  = '0;
          res_pay_nxt  = '0;
          state_nxt    = S_DONE;
          if (in_opcode == OP_INSERT) begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_stat_nxt = STAT_FULL;
            end else begin
              state_nxt = S_CMP;
            end
          end else if (in_opcode == OP_FIND) begin
            state_nxt = S_CMP;
          end else if (in_opcode inside {OP_DELETE, OP_GET, OP_UPDATE}) begin
            if (pos_bad) begin
              res_stat_nxt = STAT_RANGE;
              res_pos_nxt  = in_position;
            end else if (in_opcode == OP_UPDATE) begin
              state_nxt = S_WRITE;
            end else begin
              state_nxt = S_READ;
            end
          end else if (in_opcode == OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      S_CMP: begin
        if (op_r == OP_INSERT) begin
          ptr_nxt   = count_r;
          state_nxt = S_SCAN;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = S_SEARCH;
        end
      end
      S_SCAN: begin
        // Step down past entries whose key is not below the new key
        if (ptr_r != '0 && !lt_vec[ptr_m1[IDX_W-1:0]]) begin
          ptr_nxt = ptr_m1;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        count_nxt    = CNT_W'(count_r + CNT_W'(1));
        res_stat_nxt = STAT_OK;
        res_pos_nxt  = POS_W'(ptr_r);
        res_key_nxt  = key_r;
        res_pay_nxt  = pay_r;
        state_nxt    = S_DONE;
      end
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          if (lt_vec[mid[IDX_W-1:0]]) begin
            lo_nxt = CNT_W'(mid + CNT_W'(1));
          end else begin
            hi_nxt = mid;
          end
        end else if (lo_r < count_r && eq_vec[lo_r[IDX_W-1:0]]) begin
          rd_idx_nxt = lo_r[IDX_W-1:0];
          state_nxt  = S_READ;
        end else begin
          res_stat_nxt = STAT_MISS;
          state_nxt    = S_DONE;
        end
      end
      S_READ: begin
        res_stat_nxt = STAT_OK;
        res_pos_nxt  = POS_W'(rd_idx_r);
        res_key_nxt  = rd_key;
        res_pay_nxt  = rd_pay;
        if (op_r == OP_DELETE) begin
          count_nxt = CNT_W'(count_r - CNT_W'(1));
        end
        state_nxt = S_DONE;
      end
      S_WRITE: begin
        res_stat_nxt = STAT_OK;
        res_pos_nxt  = POS_W'(rd_idx_r);
        res_key_nxt  = key_r;
        res_pay_nxt  = pay_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Per-cell control: every cell decides from its own index
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].cmp_en = (state_r == S_CMP);
      ctl[i].sel    = SEL_HOLD;
      case (state_r)
        S_SHIFT: begin
          if (CNT_W'(i) == ptr_r) begin
            ctl[i].sel = SEL_LOAD;
          end else if (CNT_W'(i) > ptr_r && CNT_W'(i) <= count_r) begin
            ctl[i].sel = SEL_BELOW;
          end
        end
        S_READ: begin
          if (op_r == OP_DELETE && IDX_W'(i) >= rd_idx_r &&
              CNT_W'(i + 1) < count_r) begin
            ctl[i].sel = SEL_ABOVE;
          end
        end
        S_WRITE: begin
          if (IDX_W'(i) == rd_idx_r) begin
            ctl[i].sel = SEL_LOAD;
          end
        end
        default: begin
          ctl[i].sel = SEL_HOLD;
        end
      endcase
    end
  end

  // Output stage: load from the staged result, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    o_stat_nxt    = o_stat_r;
    o_pos_nxt     = o_pos_r;
    o_key_nxt     = o_key_r;
    o_pay_nxt     = o_pay_r;
    o_cnt_nxt     = o_cnt_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      o_stat_nxt    = res_stat_r;
      o_pos_nxt     = res_pos_r;
      o_key_nxt     = KEY_W'(res_key_r);
      o_pay_nxt     = PAY_W'(res_pay_r);
      o_cnt_nxt     = ECNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    rd_idx_r   <= rd_idx_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    res_stat_r <= res_stat_nxt;
    res_pos_r  <= res_pos_nxt;
    res_key_r  <= res_key_nxt;
    res_pay_r  <= res_pay_nxt;
    o_stat_r   <= o_stat_nxt;
    o_pos_r    <= o_pos_nxt;
    o_key_r    <= o_key_nxt;
    o_pay_r    <= o_pay_nxt;
    o_cnt_r    <= o_cnt_nxt;
  end

  skt_row u_row (
    .clk      (clk),
    .ctl      (ctl),
    .load_key (load_key),
    .load_pay (load_pay),
    .rd_idx   (rd_idx_r),
    .lt_vec   (lt_vec),
    .eq_vec   (eq_vec),
    .rd_key   (rd_key),
    .rd_pay   (rd_pay)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = o_stat_r;
  assign out_found_position = o_pos_r;
  assign out_entry_key      = o_key_r;
  assign out_entry_payload  = o_pay_r;
  assign out_entry_count    = o_cnt_r;

  // Hold the entry count within the table size
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table size");

  // Shift up only into a table with a free slot
  a_shift_room : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> count_r < CNT_W'(DEPTH))
    else $error("insert shift on a full table");

  // Keep the search window inside the filled entries
  a_search_window : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of range");

  // Keep the insert scan pointer at or below the count
  a_scan_ptr : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> ptr_r <= count_r)
    else $error("scan pointer above entry count");

  // Raise a result only out of the done state
  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

endmodule

/* rtl/core/skt_cell.sv */
// One entry cell of the sorted key table: key, payload and compare flags.
// Depends on skt_pkg.
module skt_cell (
  input  logic                              clk,
  input  skt_pkg::cell_ctl_t                ctl,
  input  logic [skt_pkg::KEY_BITS-1:0]      below_key,
  input  logic [skt_pkg::PAYLOAD_BITS-1:0]  below_pay,
  input  logic [skt_pkg::KEY_BITS-1:0]      above_key,
  input  logic [skt_pkg::PAYLOAD_BITS-1:0]  above_pay,
  input  logic [skt_pkg::KEY_BITS-1:0]      load_key,
  input  logic [skt_pkg::PAYLOAD_BITS-1:0]  load_pay,
  output logic [skt_pkg::KEY_BITS-1:0]      cell_key,
  output logic [skt_pkg::PAYLOAD_BITS-1:0]  cell_pay,
  output logic                              cell_lt,
  output logic                              cell_eq
);
  import skt_pkg::*;

  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic                    lt_r, eq_r;

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    case (ctl.sel)
      SEL_BELOW: begin
        key_nxt = below_key;
        pay_nxt = below_pay;
      end
      SEL_ABOVE: begin
        key_nxt = above_key;
        pay_nxt = above_pay;
      end
      SEL_LOAD: begin
        key_nxt = load_key;
        pay_nxt = load_pay;
      end
      default: begin
        key_nxt = key_r;
        pay_nxt = pay_r;
      end
    endcase
  end

  // Compare against the request key while the entry holds still
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
    if (ctl.cmp_en) begin
      lt_r <= (key_r < load_key);
      eq_r <= (key_r == load_key);
    end
  end

  assign cell_key = key_r;
  assign cell_pay = pay_r;
  assign cell_lt  = lt_r;
  assign cell_eq  = eq_r;

endmodule

/* rtl/core/skt_row.sv */
// Chain of entry cells with neighbor links, compare flag vectors and the
// single read port. Depends on skt_pkg and skt_cell.
module skt_row (
  input  logic                                    clk,
  input  skt_pkg::cell_ctl_t [skt_pkg::DEPTH-1:0] ctl,
  input  logic [skt_pkg::KEY_BITS-1:0]            load_key,
  input  logic [skt_pkg::PAYLOAD_BITS-1:0]        load_pay,
  input  logic [skt_pkg::IDX_W-1:0]               rd_idx,
  output logic [skt_pkg::DEPTH-1:0]               lt_vec,
  output logic [skt_pkg::DEPTH-1:0]               eq_vec,
  output logic [skt_pkg::KEY_BITS-1:0]            rd_key,
  output logic [skt_pkg::PAYLOAD_BITS-1:0]        rd_pay
);
  import skt_pkg::*;

  logic [KEY_BITS-1:0]     key_q [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]     bk, ak;
    logic [PAYLOAD_BITS-1:0] bp, ap;

    if (i == 0) begin : g_bot
      assign bk = '0;
      assign bp = '0;
    end else begin : g_mid_lo
      assign bk = key_q[i-1];
      assign bp = pay_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign ak = '0;
      assign ap = '0;
    end else begin : g_mid_hi
      assign ak = key_q[i+1];
      assign ap = pay_q[i+1];
    end

    skt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .below_key (bk),
      .below_pay (bp),
      .above_key (ak),
      .above_pay (ap),
      .load_key  (load_key),
      .load_pay  (load_pay),
      .cell_key  (key_q[i]),
      .cell_pay  (pay_q[i]),
      .cell_lt   (lt_vec[i]),
      .cell_eq   (eq_vec[i])
    );
  end

  assign rd_key = key_q[rd_idx];
  assign rd_pay = pay_q[rd_idx];

endmodule

/* tb/sorted_key_table_top_tb.sv */
// Self-checking testbench for sorted_key_table_top: a directed table walk, then
// phased random traffic, checked against a local model of the sorted table or a fixed response.
// Depends on skt_pkg and the sorted_key_table_top RTL.
`timescale 1ns / 100ps

module sorted_key_table_top_tb;
  import skt_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 750;
  localparam int QUIET_ITEMS   = 120;            // tail of the run with no idling
  localparam int DRAIN_CYCLES  = 2 * (DEPTH + 5);
  localparam int CYCLE_LIMIT   = 500000;

  // Opcodes the block does not define; it must answer them with a plain ok.
  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [POS_W-1:0] position;
  } table_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
    logic [KEY_W-1:0]  entry_key;
    logic [PAY_W-1:0]  entry_payload;
    logic [ECNT_W-1:0] entry_count;
  } table_resp_t;

  // One line of stimulus; a fixed response is given only where it is obvious.
  typedef struct packed {
    table_req_t  req;
    logic        fixed;
    table_resp_t resp;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OPC_W-1:0]  in_opcode = '0;
  logic [KEY_W-1:0]  in_key = '0;
  logic [PAY_W-1:0]  in_payload = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [POS_W-1:0]  out_found_position;
  logic [KEY_W-1:0]  out_entry_key;
  logic [PAY_W-1:0]  out_entry_payload;
  logic [ECNT_W-1:0] out_entry_count;

  // Local copy of the table, updated at every accepted request.
  logic [KEY_W-1:0] stored_keys [DEPTH];
  logic [PAY_W-1:0] stored_payloads [DEPTH];
  int               stored_count;

  table_resp_t awaited_responses [$];
  stim_row_t   directed_rows [$];
  table_resp_t oldest_response;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;           // chance in percent of starting an idle burst
  int          stall_left = 0;

  sorted_key_table_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_key      (out_entry_key),
    .out_entry_payload  (out_entry_payload),
    .out_entry_count    (out_entry_count)
  );

  always #CLK_HALF clk = ~clk;

  // Pack a name into a key: first character in the top byte, zeros after.
  function automatic logic [KEY_W-1:0] name_key(input string s);
    logic [KEY_W-1:0] k;
    int               n;
    k = '0;
    for (n = 0; n < s.len() && n < KEY_W / 8; n++) begin
      k[KEY_W-1-8*n -: 8] = s[n];
    end
    return k;
  endfunction

  // Apply one request to the local table and return the response it yields.
  function automatic table_resp_t apply_table_op(input table_req_t r);
    table_resp_t o;
    int          i;
    int          lo;
    int          hi;
    int          mid;
    int          pos;
    o   = '0;
    pos = int'(r.position);
    case (r.opcode)
      OP_INSERT: begin
        if (stored_count >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          // Scan down from the top so a new key lands before equal keys.
          i = stored_count;
          while (i > 0 && !(stored_keys[i-1] < r.key)) begin
            stored_keys[i]     = stored_keys[i-1];
            stored_payloads[i] = stored_payloads[i-1];
            i--;
          end
          stored_keys[i]     = r.key;
          stored_payloads[i] = r.payload;
          stored_count++;
          o.status         = STAT_OK;
          o.found_position = i[POS_W-1:0];
          o.entry_key      = r.key;
          o.entry_payload  = r.payload;
        end
      end
      OP_DELETE: begin
        if (pos >= stored_count) begin
          o.status         = STAT_RANGE;
          o.found_position = r.position;
        end else begin
          o.status         = STAT_OK;
          o.found_position = r.position;
          o.entry_key      = stored_keys[pos];
          o.entry_payload  = stored_payloads[pos];
          for (i = pos; i + 1 < stored_count; i++) begin
            stored_keys[i]     = stored_keys[i+1];
            stored_payloads[i] = stored_payloads[i+1];
          end
          stored_count--;
        end
      end
      OP_FIND: begin
        lo = 0;
        hi = stored_count;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (stored_keys[mid] < r.key) lo = mid + 1;
          else hi = mid;
        end
        if (lo < stored_count && stored_keys[lo] == r.key) begin
          o.status         = STAT_OK;
          o.found_position = lo[POS_W-1:0];
          o.entry_key      = stored_keys[lo];
          o.entry_payload  = stored_payloads[lo];
        end else begin
          o.status = STAT_MISS;
        end
      end
      OP_GET: begin
        o.found_position = r.position;
        if (pos >= stored_count) begin
          o.status = STAT_RANGE;
        end else begin
          o.status        = STAT_OK;
          o.entry_key     = stored_keys[pos];
          o.entry_payload = stored_payloads[pos];
        end
      end
      OP_UPDATE: begin
        o.found_position = r.position;
        if (pos >= stored_count) begin
          o.status = STAT_RANGE;
        end else begin
          // Written as given, even when it breaks the key order.
          stored_keys[pos]     = r.key;
          stored_payloads[pos] = r.payload;
          o.status             = STAT_OK;
          o.entry_key          = r.key;
          o.entry_payload      = r.payload;
        end
      end
      OP_CLEAR: begin
        stored_count = 0;
        o.status     = STAT_OK;
      end
      default: o.status = STAT_OK;
    endcase
    o.entry_count = stored_count[ECNT_W-1:0];
    return o;
  endfunction

  task automatic add_row(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] k,
                         input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos);
    stim_row_t row;
    row = '0;
    row.req = '{op, k, p, pos};
    directed_rows.push_back(row);
  endtask

  task automatic add_fixed_row(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] k,
                               input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos,
                               input logic [STAT_W-1:0] st, input logic [POS_W-1:0] fpos,
                               input logic [KEY_W-1:0] ek, input logic [PAY_W-1:0] ep,
                               input logic [ECNT_W-1:0] ec);
    stim_row_t row;
    row.req   = '{op, k, p, pos};
    row.fixed = 1'b1;
    row.resp  = '{st, fpos, ek, ep, ec};
    directed_rows.push_back(row);
  endtask

  // Choose a key: mostly ones already stored or from a small name pool, so
  // finds hit and equal keys pile up; the rest extremes and raw random bits.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               roll;
    roll = $urandom_range(0, 99);
    k    = '0;
    if (roll < 35 && stored_count > 0) begin
      k = stored_keys[$urandom_range(0, stored_count - 1)];
    end else if (roll < 65) begin
      k[KEY_W-1 -: 8]   = 8'h41 + 8'($urandom_range(0, 3));
      k[KEY_W-9 -: 8]   = 8'h41 + 8'($urandom_range(0, 3));
    end else if (roll < 75) begin
      k = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  function automatic stim_row_t random_row(input traffic_mode_t mode);
    stim_row_t row;
    int        roll;
    int        t_ins;
    int        t_find;
    int        t_get;
    int        t_upd;
    int        t_del;
    int        t_spare;
    row = '0;
    case (mode)
      MODE_GROW: begin
        t_ins = 55; t_find = 70; t_get = 80; t_upd = 88; t_del = 96; t_spare = 98;
      end
      MODE_SHRINK: begin
        t_ins = 15; t_find = 30; t_get = 40; t_upd = 48; t_del = 95; t_spare = 97;
      end
      default: begin
        t_ins = 30; t_find = 50; t_get = 65; t_upd = 75; t_del = 93; t_spare = 96;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < t_ins)        row.req.opcode = OP_INSERT;
    else if (roll < t_find)  row.req.opcode = OP_FIND;
    else if (roll < t_get)   row.req.opcode = OP_GET;
    else if (roll < t_upd)   row.req.opcode = OP_UPDATE;
    else if (roll < t_del)   row.req.opcode = OP_DELETE;
    else if (roll < t_spare)
      row.req.opcode = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    else                     row.req.opcode = OP_CLEAR;

    row.req.key     = pick_key();
    row.req.payload = ($urandom_range(0, 19) == 0) ?
                      {PAY_W{$urandom_range(0, 1) == 1}} : $urandom;
    // Mostly a live position; now and then anything the field allows.
    if (stored_count > 0 && $urandom_range(0, 99) < 85)
      row.req.position = POS_W'($urandom_range(0, stored_count - 1));
    else
      row.req.position = POS_W'($urandom_range(0, 31));
    // Most updates keep the stored key so the order survives.
    if (row.req.opcode == OP_UPDATE && int'(row.req.position) < stored_count &&
        $urandom_range(0, 99) < 70)
      row.req.key = stored_keys[row.req.position];
    return row;
  endfunction

  // Present one request, hold it until taken, then predict and maybe idle.
  task automatic send_request(input stim_row_t row);
    table_resp_t predicted;
    in_valid    <= 1'b1;
    in_opcode   <= row.req.opcode;
    in_key      <= row.req.key;
    in_payload  <= row.req.payload;
    in_position <= row.req.position;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_table_op(row.req);
    awaited_responses.push_back(row.fixed ? row.resp : predicted);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] expected,
                             input logic [63:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Result side: compare every accepted response with the oldest one waiting,
  // and drive stall bursts at the current idle level.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          $display("%0t: response with none outstanding: expected nothing, actual %h",
                   $time, {out_status, out_found_position, out_entry_key,
                           out_entry_payload, out_entry_count});
          mismatch_count++;
        end else begin
          oldest_response = awaited_responses.pop_front();
          check_field("status", 64'(oldest_response.status), 64'(out_status));
          check_field("found_position", 64'(oldest_response.found_position),
                      64'(out_found_position));
          check_field("entry_key", oldest_response.entry_key, out_entry_key);
          check_field("entry_payload", 64'(oldest_response.entry_payload),
                      64'(out_entry_payload));
          check_field("entry_count", 64'(oldest_response.entry_count),
                      64'(out_entry_count));
        end
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Bail out if the block hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    traffic_mode_t mode;
    int            item;
    int            idle_levels [3];
    idle_levels = '{0, 15, 40};
    mode        = MODE_GROW;
    for (item = 0; item < DEPTH; item++) begin
      stored_keys[item]     = '0;
      stored_payloads[item] = '0;
    end
    stored_count = 0;

    // Empty table: every lookup and position op must miss or be out of range.
    add_fixed_row(OP_FIND,   '0, '0, '0,    STAT_MISS,  '0,    '0, '0, 6'd0);
    add_fixed_row(OP_GET,    '0, '0, '0,    STAT_RANGE, '0,    '0, '0, 6'd0);
    add_fixed_row(OP_DELETE, '0, '0, 5'd31, STAT_RANGE, 5'd31, '0, '0, 6'd0);
    add_fixed_row(OP_UPDATE, '1, '1, '0,    STAT_RANGE, '0,    '0, '0, 6'd0);
    // Extreme keys and payloads.
    add_fixed_row(OP_INSERT, '1, '1, '1,    STAT_OK,    '0,    '1, '1, 6'd1);
    add_fixed_row(OP_INSERT, '0, '0, '0,    STAT_OK,    '0,    '0, '0, 6'd2);
    // Equal keys: the second one goes in front of the first.
    add_row(OP_INSERT, name_key("ALPHA"), 32'h0000_1111, '0);
    add_row(OP_INSERT, name_key("ALPHA"), 32'h0000_2222, '0);
    add_row(OP_FIND,   name_key("ALPHA"), '0, '0);
    add_row(OP_FIND,   name_key("BETA"),  '0, '0);
    add_row(OP_GET,    '0, '0, 5'd3);
    add_fixed_row(OP_GET, '0, '0, 5'd4, STAT_RANGE, 5'd4, '0, '0, 6'd4);
    // Break the order with an update, then search and insert around it.
    add_row(OP_UPDATE, name_key("ZULU"),  32'hDEAD_BEEF, 5'd1);
    add_row(OP_FIND,   name_key("ALPHA"), '0, '0);
    add_row(OP_INSERT, name_key("MIKE"),  32'h8000_0001, '0);
    add_row(OP_DELETE, '0, '0, '0);
    add_fixed_row(OP_DELETE, '0, '0, 5'd31, STAT_RANGE, 5'd31, '0, '0, 6'd4);
    add_row(OP_SPARE_LO, {$urandom, $urandom}, $urandom, 5'd9);
    add_row(OP_SPARE_HI, '1, '1, '1);
    add_row(OP_UPDATE, '1, '0, '0);
    add_fixed_row(OP_CLEAR, '1, '1, '1,     STAT_OK,    '0,    '0, '0, 6'd0);
    add_fixed_row(OP_FIND,  '1, '0, '0,     STAT_MISS,  '0,    '0, '0, 6'd0);
    add_fixed_row(OP_GET,   '0, '0, '0,     STAT_RANGE, '0,    '0, '0, 6'd0);

    // Hold reset, then release it once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n    <= 1'b1;
    idle_pct <= 25;
    @(posedge clk);

    // Walk the directed table.
    for (item = 0; item < directed_rows.size(); item++) begin
      send_request(directed_rows[item]);
    end

    // Random traffic in phases; each phase fills, drains or mixes, picked at random.
    for (item = 0; item < RANDOM_ITEMS; item++) begin
      if (item % 40 == 0) mode = traffic_mode_t'($urandom_range(0, 2));
      if (item >= RANDOM_ITEMS - QUIET_ITEMS) idle_pct <= 0;
      else if (item % 50 == 0) idle_pct <= idle_levels[$urandom_range(0, 2)];
      send_request(random_row(mode));
    end
    in_valid <= 1'b0;

    // Drain the outstanding responses, then watch for strays.
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
